// File: src/assert_macros.svh
// Assertion macros used by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/rgb2hsv_pkg.sv
// Types, constants and the divider step function of the RGB to HSV converter.
`timescale 1ns / 1ps

package rgb2hsv_pkg;

   localparam int CHAN_W     = 8;
   localparam int HUE_W      = 15;
   localparam int SAT_W      = 16;
   localparam int QUOT_W     = 16;
   localparam int NUM_W      = CHAN_W + QUOT_W;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
   localparam int PIPE_DEPTH = DIV_STAGES + 3;

   localparam int HUE_SIXTH = 3840;
   localparam int SAT_SCALE = 65535;

   localparam logic [HUE_W-1:0] HUE_FULL      = HUE_W'(23040);
   localparam logic [HUE_W-1:0] HUE_GREEN_OFS = HUE_W'(7680);
   localparam logic [HUE_W-1:0] HUE_BLUE_OFS  = HUE_W'(15360);

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [CHAN_W-1:0] rem;
      logic [QUOT_W-1:0] lo;
   } div_state_type;

   typedef struct packed {
      logic [CHAN_W-1:0]        mx;
      logic [CHAN_W-1:0]        range;
      sector_type               sector;
      logic signed [CHAN_W:0]   diff;
   } prep_type;

   typedef struct packed {
      logic [CHAN_W-1:0] mx;
      logic [CHAN_W-1:0] range;
      sector_type        sector;
      logic              neg;
      div_state_type     hue;
      div_state_type     sat;
   } work_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue_q;
      logic [SAT_W-1:0]  sat_q;
      logic [CHAN_W-1:0] val_q;
   } out_type;

   // Advance a restoring division by DIV_STEPS quotient bits.
   function automatic div_state_type div_steps(input div_state_type st,
                                               input logic [CHAN_W-1:0] divisor);
      div_state_type     s;
      logic [CHAN_W:0]   t;
      s = st;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t = {s.rem, s.lo[QUOT_W-1]};
         if (t >= {1'b0, divisor}) begin
            s.rem = CHAN_W'(t - {1'b0, divisor});
            s.lo  = {s.lo[QUOT_W-2:0], 1'b1};
         end else begin
            s.rem = t[CHAN_W-1:0];
            s.lo  = {s.lo[QUOT_W-2:0], 1'b0};
         end
      end
      return s;
   endfunction

endpackage

// File: src/rgb2hsv_if.sv
// Pixel and result channel interfaces of the RGB to HSV converter.
`timescale 1ns / 1ps

interface rgb2hsv_req_if;
   logic                            valid;
   logic                            ready;
   logic [rgb2hsv_pkg::CHAN_W-1:0]  red;
   logic [rgb2hsv_pkg::CHAN_W-1:0]  green;
   logic [rgb2hsv_pkg::CHAN_W-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgb2hsv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rgb2hsv_pkg::HUE_W-1:0]   hue_q;
   logic [rgb2hsv_pkg::SAT_W-1:0]   sat_q;
   logic [rgb2hsv_pkg::CHAN_W-1:0]  val_q;

   modport source (output valid, hue_q, sat_q, val_q, input ready);
   modport sink (input valid, hue_q, sat_q, val_q, output ready);
endinterface

// File: src/rgb_to_hsv_converter.sv
// RGB to HSV converter: pipelined max/min, two restoring dividers, hue assembly.
//
// req_chan carries one RGB pixel of three 8-bit channels per transfer; rsp_chan returns one
// result per pixel, in order: hue_q (1/64 degree), sat_q (1/65535) and val_q.
// Both channels transfer when valid and ready are high at a rising edge.
// From the pixel transfer to rsp_chan.valid a pixel passes one stage
// for max/min, one for the dividends, four divider stages retiring four
// quotient bits each for hue and saturation in parallel, and the output
// register that assembles the hue. Throughput is one pixel per cycle while not stalled.
// When rsp_chan.ready is low with a result waiting, every stage holds,
// empty ones included, and req_chan.ready drops, so no pixel is lost or
// repeated. Synchronous reset clears all valid bits; the pipeline is empty
// and ready in the first cycle after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_hsv_converter (
   input logic           clock,
   input logic           reset,
   rgb2hsv_req_if.sink   req_chan,
   rgb2hsv_rsp_if.source rsp_chan
);

   localparam int LAST = rgb2hsv_pkg::PIPE_DEPTH - 1;
   localparam int NDIV = rgb2hsv_pkg::DIV_STAGES;

   logic [rgb2hsv_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic [rgb2hsv_pkg::PIPE_DEPTH-1:0] vld_in;
   logic                               advance;

   rgb2hsv_pkg::prep_type prep_ff;
   rgb2hsv_pkg::prep_type prep_in;
   rgb2hsv_pkg::work_type work_ff [NDIV+1];
   rgb2hsv_pkg::work_type work_in [NDIV+1];
   rgb2hsv_pkg::out_type  out_ff;
   rgb2hsv_pkg::out_type  out_in;

   assign advance        = !vld_ff[LAST] || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      vld_in = vld_ff;
      if (advance) begin
         vld_in = {vld_ff[LAST-1:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // max, min, range and the channel pair that picks the hue formula
   always_comb begin
      logic [rgb2hsv_pkg::CHAN_W-1:0] mx;
      logic [rgb2hsv_pkg::CHAN_W-1:0] mn;
      mx = req_chan.red;
      if (req_chan.green > mx) mx = req_chan.green;
      if (req_chan.blue > mx) mx = req_chan.blue;
      mn = req_chan.red;
      if (req_chan.green < mn) mn = req_chan.green;
      if (req_chan.blue < mn) mn = req_chan.blue;
      prep_in.mx    = mx;
      prep_in.range = mx - mn;
      if (mx == req_chan.red) begin
         prep_in.sector = rgb2hsv_pkg::SECTOR_RED;
         prep_in.diff   = $signed({1'b0, req_chan.green}) - $signed({1'b0, req_chan.blue});
      end else if (mx == req_chan.green) begin
         prep_in.sector = rgb2hsv_pkg::SECTOR_GREEN;
         prep_in.diff   = $signed({1'b0, req_chan.blue}) - $signed({1'b0, req_chan.red});
      end else begin
         prep_in.sector = rgb2hsv_pkg::SECTOR_BLUE;
         prep_in.diff   = $signed({1'b0, req_chan.red}) - $signed({1'b0, req_chan.green});
      end
   end

   // dividends and divider stages
   always_comb begin
      logic [rgb2hsv_pkg::CHAN_W:0]  mag;
      logic [rgb2hsv_pkg::NUM_W-1:0] hue_num;
      logic [rgb2hsv_pkg::NUM_W-1:0] sat_num;
      mag = prep_ff.diff[rgb2hsv_pkg::CHAN_W] ? (~prep_ff.diff + 1'b1) : prep_ff.diff;
      hue_num = rgb2hsv_pkg::NUM_W'(mag[rgb2hsv_pkg::CHAN_W-1:0])
              * rgb2hsv_pkg::NUM_W'(rgb2hsv_pkg::HUE_SIXTH);
      sat_num = rgb2hsv_pkg::NUM_W'(prep_ff.range)
              * rgb2hsv_pkg::NUM_W'(rgb2hsv_pkg::SAT_SCALE);
      work_in[0].mx      = prep_ff.mx;
      work_in[0].range   = prep_ff.range;
      work_in[0].sector  = prep_ff.sector;
      work_in[0].neg     = prep_ff.diff[rgb2hsv_pkg::CHAN_W];
      work_in[0].hue.rem = hue_num[rgb2hsv_pkg::NUM_W-1:rgb2hsv_pkg::QUOT_W];
      work_in[0].hue.lo  = hue_num[rgb2hsv_pkg::QUOT_W-1:0];
      work_in[0].sat.rem = sat_num[rgb2hsv_pkg::NUM_W-1:rgb2hsv_pkg::QUOT_W];
      work_in[0].sat.lo  = sat_num[rgb2hsv_pkg::QUOT_W-1:0];
      for (int k = 1; k <= NDIV; k++) begin
         work_in[k]     = work_ff[k-1];
         work_in[k].hue = rgb2hsv_pkg::div_steps(work_ff[k-1].hue, work_ff[k-1].range);
         work_in[k].sat = rgb2hsv_pkg::div_steps(work_ff[k-1].sat, work_ff[k-1].mx);
      end
   end

   // hue assembly: floor of a negative ratio is minus the ceiling of its magnitude
   always_comb begin
      logic [rgb2hsv_pkg::HUE_W-1:0] quot;
      logic [rgb2hsv_pkg::HUE_W-1:0] quot_up;
      logic [rgb2hsv_pkg::HUE_W-1:0] hue;
      quot    = work_ff[NDIV].hue.lo[rgb2hsv_pkg::HUE_W-1:0];
      quot_up = quot + rgb2hsv_pkg::HUE_W'(work_ff[NDIV].hue.rem != '0);
      case (work_ff[NDIV].sector)
         rgb2hsv_pkg::SECTOR_RED: begin
            hue = work_ff[NDIV].neg ? (rgb2hsv_pkg::HUE_FULL - quot_up) : quot;
         end
         rgb2hsv_pkg::SECTOR_GREEN: begin
            hue = work_ff[NDIV].neg ? (rgb2hsv_pkg::HUE_GREEN_OFS - quot_up)
                                    : (rgb2hsv_pkg::HUE_GREEN_OFS + quot);
         end
         rgb2hsv_pkg::SECTOR_BLUE: begin
            hue = work_ff[NDIV].neg ? (rgb2hsv_pkg::HUE_BLUE_OFS - quot_up)
                                    : (rgb2hsv_pkg::HUE_BLUE_OFS + quot);
         end
         default: begin
            hue = '0;
         end
      endcase
      if (work_ff[NDIV].range == '0) begin
         hue = '0;
      end
      out_in.hue_q = hue;
      out_in.sat_q = (work_ff[NDIV].mx == '0) ? '0 : work_ff[NDIV].sat.lo;
      out_in.val_q = work_ff[NDIV].mx;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_ff <= prep_in;
         for (int k = 0; k <= NDIV; k++) begin
            work_ff[k] <= work_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid = vld_ff[LAST];
   assign rsp_chan.hue_q = out_ff.hue_q;
   assign rsp_chan.sat_q = out_ff.sat_q;
   assign rsp_chan.val_q = out_ff.val_q;

   `ASSERT_NEXT(a_transfer_enters, clock, reset, req_chan.valid && req_chan.ready, vld_ff[0], "accepted pixel did not enter the pipeline")
   `ASSERT_IMPLIES(a_hue_range, clock, reset, rsp_chan.valid, rsp_chan.hue_q < rgb2hsv_pkg::HUE_FULL, "hue out of range")
   `ASSERT_IMPLIES(a_black_pixel, clock, reset, rsp_chan.valid && (rsp_chan.val_q == '0), (rsp_chan.sat_q == '0) && (rsp_chan.hue_q == '0), "black pixel with nonzero hue or saturation")
   `ASSERT_IMPLIES(a_gray_pixel, clock, reset, rsp_chan.valid && (rsp_chan.sat_q == '0), rsp_chan.hue_q == '0, "gray pixel with nonzero hue")

endmodule
